/* rtl/core/mide_pkg.sv */
// Shared types and constants for the multi-input debounce block.
`default_nettype none
package mide_pkg;

    localparam int CHANNELS = 8;
    localparam int PINS = 8;
    localparam int TICK_W = 16;
    localparam int IDX_W = 3;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'(50 * 16);
    localparam logic [PINS-1:0] INVERT_RESET = 8'h00;
    localparam logic [PINS-1:0] RISING_RESET = 8'hFF;
    localparam logic [PINS-1:0] FALLING_RESET = 8'hFF;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_INVERT   = 2'd1,
        REG_RISING   = 2'd2,
        REG_FALLING  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic fire;
        logic lvl;
    } chan_evt_t;

endpackage
`default_nettype wire

/* rtl/core/multi_input_debounce_edge_events_top.sv */
// Top level of the multi-input debouncer with edge events.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: pin_levels[7:0], toggle_events[15:8]
//   m_axis    out        tdata: channel_index[2:0], level[3], rising[4]; tlast: last_event
//   apb       in/out     debounce_ticks, invert_mask, rising_mask, falling_mask
//
// A tick request is taken on its handshake; all channels update in parallel at that edge.
// Its events leave one per cycle while m_tready is high, from the pending-event register, lowest channel first.
// A new tick is taken when no event of the previous tick is left, or when the last one
// left is being taken.
// Reset clears all channel state and loads the register defaults.
`default_nettype none
module multi_input_debounce_edge_events_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pin_levels[7:0], toggle_events[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // channel_index[2:0], level[3], rising[4], zero[7:5]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mide_pkg::TICK_W-1:0] debounce_reg;
    logic [mide_pkg::PINS-1:0]   invert_reg;
    logic [mide_pkg::PINS-1:0]   rising_reg;
    logic [mide_pkg::PINS-1:0]   falling_reg;
    logic [mide_pkg::TICK_W-1:0] len;
    logic                        cfg_wr;
    mide_pkg::reg_idx_t          reg_idx;

    logic [mide_pkg::PINS-1:0]   pins;
    logic [mide_pkg::PINS-1:0]   toggles;
    logic [mide_pkg::PINS-1:0]   fire_vec;
    logic [mide_pkg::PINS-1:0]   lvl_vec;
    logic                        s_acc;
    logic                        m_acc;

    logic [mide_pkg::PINS-1:0]   pend_reg;
    logic [mide_pkg::PINS-1:0]   pend_next;
    logic [mide_pkg::PINS-1:0]   lvl_reg;
    logic [mide_pkg::PINS-1:0]   lvl_next;
    logic [mide_pkg::PINS-1:0]   pend_rest;
    logic [mide_pkg::IDX_W-1:0]  idx;
    logic                        single;
    logic                        out_lvl;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = mide_pkg::reg_idx_t'(paddr[3:2]);
    assign len     = (debounce_reg == '0) ? 16'd1 : debounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= mide_pkg::DEBOUNCE_RESET;
            invert_reg   <= mide_pkg::INVERT_RESET;
            rising_reg   <= mide_pkg::RISING_RESET;
            falling_reg  <= mide_pkg::FALLING_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                mide_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                mide_pkg::REG_INVERT:   invert_reg   <= pwdata[7:0];
                mide_pkg::REG_RISING:   rising_reg   <= pwdata[7:0];
                mide_pkg::REG_FALLING:  falling_reg  <= pwdata[7:0];
                default:                debounce_reg <= debounce_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mide_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            mide_pkg::REG_INVERT:   prdata = {24'd0, invert_reg};
            mide_pkg::REG_RISING:   prdata = {24'd0, rising_reg};
            mide_pkg::REG_FALLING:  prdata = {24'd0, falling_reg};
            default:                prdata = '0;
        endcase
    end

    assign pins    = s_tdata[7:0];
    assign toggles = s_tdata[15:8];
    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = m_tvalid && m_tready;

    for (genvar c = 0; c < mide_pkg::PINS; c++)
    begin : g_chan
        if (c < mide_pkg::CHANNELS)
        begin : g_used
            mide_pkg::chan_evt_t evt;

            mide_chan u_chan (
                .clk     (clk),
                .rst_n   (rst_n),
                .tick    (s_acc),
                .toggle  (toggles[c]),
                .pin     (pins[c]),
                .invert  (invert_reg[c]),
                .rise_en (rising_reg[c]),
                .fall_en (falling_reg[c]),
                .len     (len),
                .evt     (evt)
            );

            assign fire_vec[c] = evt.fire;
            assign lvl_vec[c]  = evt.lvl;
        end
        else
        begin : g_unused
            assign fire_vec[c] = 1'b0;
            assign lvl_vec[c]  = 1'b0;
        end
    end

    always_comb
    begin
        idx = '0;
        for (int i = mide_pkg::PINS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                idx = mide_pkg::IDX_W'(i);
            end
        end
    end

    assign pend_rest = pend_reg & (pend_reg - 8'd1);
    assign single    = (pend_rest == '0);
    assign out_lvl   = lvl_reg[idx];

    assign m_tvalid = (pend_reg != '0);
    assign m_tlast  = single;
    assign m_tdata  = {3'd0, out_lvl, out_lvl, idx};
    assign s_tready = !m_tvalid || (m_tready && single);

    always_comb
    begin
        pend_next = pend_reg;
        lvl_next  = lvl_reg;
        if (s_acc)
        begin
            pend_next = fire_vec;
            lvl_next  = lvl_vec;
        end
        else if (m_acc)
        begin
            pend_next = pend_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input not ready while no event is pending.");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_tlast && !s_acc) |=> !m_tvalid)
        else $error("Events remain after the last event of a tick was taken.");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && !m_tlast) |=> (m_tvalid && !s_tready) || (m_tvalid && m_tready && m_tlast)
            || (m_tvalid && m_tready && !m_tlast) || m_tvalid)
        else $error("Pending events lost before the last event of a tick.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[2:0]) < mide_pkg::CHANNELS))
        else $error("Event reported for a channel that does not exist.");

endmodule
`default_nettype wire

/* rtl/core/mide_chan.sv */
// One debounce channel: countdown, counting flag and stable level.
`default_nettype none
module mide_chan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick,
    input  logic                              toggle,
    input  logic                              pin,
    input  logic                              invert,
    input  logic                              rise_en,
    input  logic                              fall_en,
    input  logic [mide_pkg::TICK_W-1:0]       len,
    output mide_pkg::chan_evt_t               evt
);

    logic [mide_pkg::TICK_W-1:0] cd_reg;
    logic [mide_pkg::TICK_W-1:0] cd_next;
    logic [mide_pkg::TICK_W-1:0] dec;
    logic                        counting_reg;
    logic                        counting_next;
    logic                        stable_reg;
    logic                        stable_next;
    logic                        lvl;

    always_comb
    begin
        cd_next       = cd_reg;
        counting_next = counting_reg;
        stable_next   = stable_reg;
        evt           = '0;
        dec           = (cd_reg != '0) ? cd_reg - 16'd1 : cd_reg;
        lvl           = pin ^ invert;
        if (tick)
        begin
            if (toggle)
            begin
                cd_next       = len;
                counting_next = 1'b1;
            end
            else if (counting_reg)
            begin
                cd_next = dec;
                if (dec == '0)
                begin
                    counting_next = 1'b0;
                    stable_next   = lvl;
                    evt.lvl       = lvl;
                    evt.fire      = (lvl && !stable_reg && rise_en) ||
                                    (!lvl && stable_reg && fall_en);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg       <= '0;
            counting_reg <= 1'b0;
            stable_reg   <= 1'b0;
        end
        else
        begin
            cd_reg       <= cd_next;
            counting_reg <= counting_next;
            stable_reg   <= stable_next;
        end
    end

endmodule
`default_nettype wire
